/* rtl/core/pmc_pkg.sv */
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared constants, codes and payload types of the paged memory word cache.
// ----------------------------------------------------------------------------
package pmc_pkg;

    localparam int NUM_PAGES      = 16;
    localparam int PAGE_BYTES     = 4096;
    localparam int CACHE_LIMIT    = 32;
    localparam int NUM_LINES      = CACHE_LIMIT + 1;
    localparam int WORDS_PER_PAGE = PAGE_BYTES / 4;
    localparam int WOFF_W         = $clog2(WORDS_PER_PAGE);
    localparam int PIDX_W         = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int MEM_DEPTH      = NUM_PAGES * WORDS_PER_PAGE;
    localparam int MEM_AW         = $clog2(MEM_DEPTH);
    localparam int LIDX_W         = $clog2(NUM_LINES);
    localparam int AGE_W          = $clog2(NUM_LINES);
    localparam int CNT_W          = $clog2(NUM_LINES + 1);
    localparam int BASE_W         = 20;
    localparam int TAG_W          = 30;

    localparam logic [2:0] CMD_ALLOC    = 3'd0;
    localparam logic [2:0] CMD_RAW_RD   = 3'd1;
    localparam logic [2:0] CMD_RAW_WR   = 3'd2;
    localparam logic [2:0] CMD_CHK_RD   = 3'd3;
    localparam logic [2:0] CMD_CHK_WR   = 3'd4;
    localparam logic [2:0] CMD_CACHE_LD = 3'd5;
    localparam logic [2:0] CMD_CACHE_RD = 3'd6;
    localparam logic [2:0] CMD_CACHE_WR = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BUS      = 3'd1;
    localparam logic [2:0] ST_SEGV     = 3'd2;
    localparam logic [2:0] ST_UNMAPPED = 3'd3;
    localparam logic [2:0] ST_MISS     = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [2:0] ACC_READ  = 3'b001;
    localparam logic [2:0] ACC_WRITE = 3'b010;
    localparam logic [2:0] ACC_EXEC  = 3'b100;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] address;
        logic [31:0] write_data;
        logic        privileged;
        logic        fetch;
        logic [2:0]  page_permission;
    } req_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  status;
        logic        cache_hit;
    } rsp_item_t;

    typedef struct packed {
        logic              en;
        logic [PIDX_W-1:0] idx;
        logic [BASE_W-1:0] base;
        logic              priv_only;
        logic [2:0]        access;
    } page_wr_t;

    typedef struct packed {
        logic              hit;
        logic [PIDX_W-1:0] idx;
        logic              priv_only;
        logic [2:0]        access;
    } page_look_t;

    typedef struct packed {
        logic              touch;
        logic              evict;
        logic              fill;
        logic              set_dirty;
        logic [LIDX_W-1:0] idx;
        logic [TAG_W-1:0]  tag;
        logic [2:0]        access;
    } dir_op_t;

    typedef struct packed {
        logic              hit;
        logic [LIDX_W-1:0] hit_idx;
        logic [2:0]        hit_access;
        logic              full;
        logic [LIDX_W-1:0] victim_idx;
        logic [TAG_W-1:0]  victim_tag;
        logic              victim_dirty;
        logic [LIDX_W-1:0] free_idx;
    } dir_look_t;

endpackage

/* rtl/core/pmc_ram.sv */
// ----------------------------------------------------------------------------
// pmc_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* rtl/core/pmc_page_table.sv */
// ----------------------------------------------------------------------------
// pmc_page_table
// Page slots with base, privilege mark and access bits; two parallel lookups.
// ----------------------------------------------------------------------------
module pmc_page_table import pmc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  page_wr_t          wr,
    input  logic [BASE_W-1:0] base_a,
    output page_look_t        look_a,
    input  logic [BASE_W-1:0] base_b,
    output page_look_t        look_b,
    output logic              free_found,
    output logic [PIDX_W-1:0] free_idx
);

    logic [NUM_PAGES-1:0] valid_reg;
    logic [BASE_W-1:0]    base_reg   [NUM_PAGES];
    logic                 priv_reg   [NUM_PAGES];
    logic [2:0]           access_reg [NUM_PAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            base_reg[wr.idx]   <= wr.base;
            priv_reg[wr.idx]   <= wr.priv_only;
            access_reg[wr.idx] <= wr.access;
        end
    end

    always_comb
    begin
        look_a     = '0;
        look_b     = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_PAGES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && base_reg[i] == base_a)
            begin
                look_a.hit       = 1'b1;
                look_a.idx       = PIDX_W'(i);
                look_a.priv_only = priv_reg[i];
                look_a.access    = access_reg[i];
            end
            if (valid_reg[i] && base_reg[i] == base_b)
            begin
                look_b.hit       = 1'b1;
                look_b.idx       = PIDX_W'(i);
                look_b.priv_only = priv_reg[i];
                look_b.access    = access_reg[i];
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = PIDX_W'(i);
            end
        end
    end

endmodule

/* rtl/core/pmc_line_dir.sv */
// ----------------------------------------------------------------------------
// pmc_line_dir
// Cache line directory: tags, valid, dirty, access bits and LRU ages.
// ----------------------------------------------------------------------------
module pmc_line_dir import pmc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [TAG_W-1:0] look_tag,
    input  dir_op_t          op,
    output dir_look_t        look
);

    logic [NUM_LINES-1:0] valid_reg;
    logic [NUM_LINES-1:0] dirty_reg;
    logic [AGE_W-1:0]     age_reg    [NUM_LINES];
    logic [TAG_W-1:0]     tag_reg    [NUM_LINES];
    logic [2:0]           access_reg [NUM_LINES];
    logic [CNT_W-1:0]     cnt_reg;
    logic [AGE_W-1:0]     oldest_age;

    // Valid ages are always exactly 0 .. count-1, so the oldest line is the
    // one whose age equals count-1.
    assign oldest_age = AGE_W'(cnt_reg - 1'b1);

    always_comb
    begin
        look      = '0;
        look.full = (cnt_reg == CNT_W'(NUM_LINES));
        for (int i = NUM_LINES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_reg[i] == look_tag)
            begin
                look.hit        = 1'b1;
                look.hit_idx    = LIDX_W'(i);
                look.hit_access = access_reg[i];
            end
            if (valid_reg[i] && age_reg[i] == oldest_age)
            begin
                look.victim_idx   = LIDX_W'(i);
                look.victim_tag   = tag_reg[i];
                look.victim_dirty = dirty_reg[i];
            end
            if (!valid_reg[i])
            begin
                look.free_idx = LIDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            if (op.touch)
            begin
                for (int i = 0; i < NUM_LINES; i++)
                begin
                    if (valid_reg[i] && age_reg[i] < age_reg[op.idx])
                    begin
                        age_reg[i] <= age_reg[i] + 1'b1;
                    end
                end
                age_reg[op.idx] <= '0;
            end
            if (op.evict)
            begin
                valid_reg[op.idx] <= 1'b0;
                dirty_reg[op.idx] <= 1'b0;
                cnt_reg           <= cnt_reg - 1'b1;
            end
            if (op.fill)
            begin
                for (int i = 0; i < NUM_LINES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        age_reg[i] <= age_reg[i] + 1'b1;
                    end
                end
                valid_reg[op.idx] <= 1'b1;
                dirty_reg[op.idx] <= 1'b0;
                age_reg[op.idx]   <= '0;
                cnt_reg           <= cnt_reg + 1'b1;
            end
            if (op.set_dirty)
            begin
                dirty_reg[op.idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.fill)
        begin
            tag_reg[op.idx]    <= op.tag;
            access_reg[op.idx] <= op.access;
        end
    end

endmodule

/* rtl/core/paged_memory_lru_word_cache.sv */
// ----------------------------------------------------------------------------
// paged_memory_lru_word_cache
// Paged word memory with page permissions and an LRU write-back word cache.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on req (req_valid/req_stall) and exactly one
// result beat leaves on rsp (rsp_valid/rsp_stall). A beat moves on an edge
// with valid high and stall low.
// Commands run one at a time. Each passes from accept through S_LOOK to S_RESP
// and then into the result register: reads (raw, checked and cache) pass
// through S_MWAIT or S_CWAIT; a cache load miss passes through S_WB when a
// line must be evicted, then S_FCHK, and S_FILL when the fill read succeeds.
// An alloc zero-fills its page in S_ZERO through the single word memory port,
// one word a cycle.
// A new command is taken the cycle after the previous one has its result in
// the output register. A stalled receiver holds only that one result; the
// block then waits before it can post the next one.
// Reset clears the page table, the cache directory and both handshakes.
// Word memory contents need no clearing since alloc zero-fills every page.
// ----------------------------------------------------------------------------
module paged_memory_lru_word_cache import pmc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LOOK  = 9'b000000010,
        S_MWAIT = 9'b000000100,
        S_CWAIT = 9'b000001000,
        S_WB    = 9'b000010000,
        S_FCHK  = 9'b000100000,
        S_FILL  = 9'b001000000,
        S_ZERO  = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    req_item_t         cmd_reg, cmd_next;
    rsp_item_t         res_reg, res_next;
    rsp_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [PIDX_W-1:0] zpage_reg, zpage_next;
    logic [WOFF_W-1:0] zcnt_reg, zcnt_next;

    page_wr_t          pwr;
    page_look_t        look_a, look_b;
    logic              free_found;
    logic [PIDX_W-1:0] free_idx;
    dir_op_t           dop;
    dir_look_t         dl;

    logic              mem_en, mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [31:0]       mem_wdata, mem_rdata;
    logic              val_en, val_we;
    logic [LIDX_W-1:0] val_addr;
    logic [31:0]       val_wdata, val_rdata;

    logic              misaligned;
    logic [2:0]        need;
    logic              perm_fail;
    logic [MEM_AW-1:0] word_addr;

    pmc_page_table u_pages (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (pwr),
        .base_a     (cmd_reg.address[31:12]),
        .look_a     (look_a),
        .base_b     (dl.victim_tag[TAG_W-1:WOFF_W]),
        .look_b     (look_b),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    pmc_line_dir u_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .look_tag (cmd_reg.address[31:2]),
        .op       (dop),
        .look     (dl)
    );

    pmc_ram #(.WIDTH(32), .DEPTH(MEM_DEPTH)) u_words (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    pmc_ram #(.WIDTH(32), .DEPTH(NUM_LINES)) u_values (
        .clk   (clk),
        .en    (val_en),
        .we    (val_we),
        .addr  (val_addr),
        .wdata (val_wdata),
        .rdata (val_rdata)
    );

    assign misaligned = (cmd_reg.address[1:0] != 2'b00);
    assign word_addr  = MEM_AW'({look_a.idx, cmd_reg.address[11:2]});
    assign perm_fail  = ((look_a.access & need) != need) ||
                        (look_a.priv_only && !cmd_reg.privileged);

    always_comb
    begin
        case (cmd_reg.command)
            CMD_CHK_RD: need = cmd_reg.fetch ? (ACC_READ | ACC_EXEC) : ACC_READ;
            CMD_CHK_WR: need = ACC_WRITE;
            default:    need = ACC_READ;
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        zpage_next     = zpage_reg;
        zcnt_next      = zcnt_reg;
        pwr            = '0;
        dop            = '0;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = word_addr;
        mem_wdata      = cmd_reg.write_data;
        val_en         = 1'b0;
        val_we         = 1'b0;
        val_addr       = dl.hit_idx;
        val_wdata      = cmd_reg.write_data;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req;
                    state_next = S_LOOK;
                end
            end

            S_LOOK:
            begin
                res_next   = '{read_data: '0, status: ST_OK, cache_hit: 1'b0};
                state_next = S_RESP;
                case (cmd_reg.command)
                    CMD_ALLOC:
                    begin
                        if (look_a.hit || free_found)
                        begin
                            pwr.en        = 1'b1;
                            pwr.idx       = look_a.hit ? look_a.idx : free_idx;
                            pwr.base      = cmd_reg.address[31:12];
                            pwr.priv_only = cmd_reg.privileged;
                            pwr.access    = cmd_reg.page_permission;
                            zpage_next    = pwr.idx;
                            zcnt_next     = '0;
                            state_next    = S_ZERO;
                        end
                        else
                        begin
                            res_next.status = ST_FULL;
                        end
                    end
                    CMD_RAW_RD, CMD_RAW_WR, CMD_CHK_RD, CMD_CHK_WR:
                    begin
                        if (misaligned)
                        begin
                            res_next.status = ST_BUS;
                        end
                        else if (!look_a.hit)
                        begin
                            res_next.status = ST_UNMAPPED;
                        end
                        else if ((cmd_reg.command == CMD_CHK_RD ||
                                  cmd_reg.command == CMD_CHK_WR) && perm_fail)
                        begin
                            res_next.status = ST_SEGV;
                        end
                        else
                        begin
                            mem_en = 1'b1;
                            if (cmd_reg.command == CMD_RAW_WR ||
                                cmd_reg.command == CMD_CHK_WR)
                            begin
                                mem_we = 1'b1;
                            end
                            else
                            begin
                                state_next = S_MWAIT;
                            end
                        end
                    end
                    CMD_CACHE_LD:
                    begin
                        if (misaligned)
                        begin
                            res_next.status = ST_BUS;
                        end
                        else if (dl.hit)
                        begin
                            dop.touch          = 1'b1;
                            dop.idx            = dl.hit_idx;
                            res_next.cache_hit = 1'b1;
                        end
                        else if (dl.full)
                        begin
                            // Fetch the victim's value for a possible write-back.
                            val_en     = 1'b1;
                            val_addr   = dl.victim_idx;
                            state_next = S_WB;
                        end
                        else
                        begin
                            state_next = S_FCHK;
                        end
                    end
                    CMD_CACHE_RD, CMD_CACHE_WR:
                    begin
                        if (misaligned || !dl.hit)
                        begin
                            res_next.status = ST_MISS;
                        end
                        else if (cmd_reg.command == CMD_CACHE_RD)
                        begin
                            if ((dl.hit_access & ACC_READ) == 3'b000)
                            begin
                                res_next.status = ST_SEGV;
                            end
                            else
                            begin
                                val_en     = 1'b1;
                                state_next = S_CWAIT;
                            end
                        end
                        else if ((dl.hit_access & ACC_WRITE) == 3'b000)
                        begin
                            res_next.status = ST_SEGV;
                        end
                        else
                        begin
                            val_en        = 1'b1;
                            val_we        = 1'b1;
                            dop.set_dirty = 1'b1;
                            dop.idx       = dl.hit_idx;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_MISS;
                    end
                endcase
            end

            S_MWAIT:
            begin
                res_next.read_data = mem_rdata;
                state_next         = S_RESP;
            end

            S_CWAIT:
            begin
                res_next.read_data = val_rdata;
                state_next         = S_RESP;
            end

            S_WB:
            begin
                if (dl.victim_dirty && look_b.hit)
                begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = MEM_AW'({look_b.idx, dl.victim_tag[WOFF_W-1:0]});
                    mem_wdata = val_rdata;
                end
                dop.evict  = 1'b1;
                dop.idx    = dl.victim_idx;
                state_next = S_FCHK;
            end

            S_FCHK:
            begin
                if (!look_a.hit)
                begin
                    res_next.status = ST_UNMAPPED;
                    state_next      = S_RESP;
                end
                else if (perm_fail)
                begin
                    res_next.status = ST_SEGV;
                    state_next      = S_RESP;
                end
                else
                begin
                    mem_en     = 1'b1;
                    state_next = S_FILL;
                end
            end

            S_FILL:
            begin
                dop.fill   = 1'b1;
                dop.idx    = dl.free_idx;
                dop.tag    = cmd_reg.address[31:2];
                dop.access = look_a.access;
                val_en     = 1'b1;
                val_we     = 1'b1;
                val_addr   = dl.free_idx;
                val_wdata  = mem_rdata;
                state_next = S_RESP;
            end

            S_ZERO:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = MEM_AW'({zpage_reg, zcnt_reg});
                mem_wdata = '0;
                zcnt_next = zcnt_reg + 1'b1;
                if (zcnt_reg == '1)
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
        zpage_reg <= zpage_next;
        zcnt_reg  <= zcnt_next;
    end

endmodule

/* rtl/core/pmc_checker.sv */
// ----------------------------------------------------------------------------
// pmc_checker
// Port-level checks on the paged memory word cache, bound to the top level.
// ----------------------------------------------------------------------------
module pmc_checker import pmc_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_item_t req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    // A stalled result beat stays offered and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // Faults and misses never carry data.
    a_fault_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |-> rsp.read_data == '0)
        else $error("read data on a failing result");

    // A cache hit is a successful load and returns no data.
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.cache_hit |-> rsp.status == ST_OK && rsp.read_data == '0)
        else $error("cache hit with bad status or data");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_BUS ||
                      rsp.status == ST_SEGV || rsp.status == ST_UNMAPPED ||
                      rsp.status == ST_MISS || rsp.status == ST_FULL)
        else $error("undefined status code");

    // A command accepted closes the input, so no second command is taken next.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second command taken back to back");

endmodule

bind paged_memory_lru_word_cache pmc_checker u_pmc_checker (.*);
